// File: rtl/core/bbe_pkg.sv
package bbe_pkg;

  // Field and arithmetic widths
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned RGB_W       = 3 * CH_W;
  localparam int unsigned SUM_W       = 12;  // nine 8-bit terms
  localparam int unsigned NUM_W       = 13;  // 2*sum + count
  localparam int unsigned CNT_W       = 4;   // neighbor count, 1 to 9
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  // Request kinds on the input channel
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] pix_blue;
    logic [CH_W-1:0] pix_green;
    logic [CH_W-1:0] pix_red;
  } bbe_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            frame_last;
  } bbe_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SUM,
    S_SCALE
  } bbe_state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch request, start line store read
    logic update;  // shift window, write line store, step counters
    logic sum;     // add up neighborhood
    logic scale;   // divide and load output register
  } bbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;      // current request produces a result
    logic out_full;  // output register holds a result not taken this cycle
  } bbe_stat_t;

  // ceil(2^RECIP_SHIFT / (2*count)); exact for numerators below 2^NUM_W
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    unique case (count)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      4'd9:    r = 20'd58255;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/bbe_ram.sv
module bbe_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bbe_ctrl.sv
module bbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bbe_pkg::bbe_stat_t stat_i,
  output bbe_pkg::bbe_cmd_t  cmd_o
);

  import bbe_pkg::*;

  bbe_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        // hold until the output register can take the result
        if (!stat_i.out_full) begin
          cmd_o.scale = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/bbe_datapath.sv
module bbe_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  bbe_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [bbe_pkg::CFG_W-1:0] cfg_data_i,
  input  bbe_pkg::bbe_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bbe_pkg::bbe_out_t         out_data_o,
  input  bbe_pkg::bbe_cmd_t         cmd_i,
  output bbe_pkg::bbe_stat_t        stat_o
);

  import bbe_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);   // column, holds width
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);  // holds height
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);  // row, runs into drain
  localparam int unsigned OW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int unsigned H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
  localparam int unsigned TOTAL_RST = W_RST * H_RST;

  // Frame geometry
  logic [CW-1:0] w_q, w_wr;
  logic [HW-1:0] h_q, h_wr;
  logic [OW-1:0] total_q;
  logic [CW+HW-1:0] area;

  // Stream position
  logic [RW-1:0] in_row_q;
  logic [CW-1:0] in_col_q, col_inc;
  logic [OW-1:0] out_count_q, cnt_inc;

  // Request and window
  logic [RGB_W-1:0]   pix_q;
  logic [RGB_W-1:0]   win_q [9];
  logic [2*RGB_W-1:0] ram_rd, ram_wr;

  // Per-result flags
  logic emit_c, last_c, emit_q, last_q;
  logic col_nz;
  logic [RW-1:0] cr;
  logic [CW-1:0] cc;
  logic top_ok, bot_ok, left_ok, right_ok;
  logic [2:0] row_ok_q, col_ok_q;

  // Sum and scale
  logic [SUM_W-1:0]   sum_c [3];
  logic [1:0]         rows_n, cols_n;
  logic [CNT_W-1:0]   count_c;
  logic [NUM_W-1:0]   num_q [3];
  logic [RECIP_W-1:0] recip_q;
  logic [PROD_W-1:0]  prod [3];

  logic     out_valid_q;
  bbe_out_t out_q;

  // Clamp register writes into the supported range
  always_comb begin
    if (cfg_data_i == '0) begin
      w_wr = CW'(1);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      w_wr = CW'(MAX_WIDTH);
    end else begin
      w_wr = CW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_wr = HW'(1);
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      h_wr = HW'(MAX_HEIGHT);
    end else begin
      h_wr = HW'(cfg_data_i);
    end
  end

  assign area = (CW+HW)'(w_q) * (CW+HW)'(h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= CW'(W_RST);
      h_q     <= HW'(H_RST);
      total_q <= OW'(TOTAL_RST);
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_WIDTH) begin
        w_q <= w_wr;
      end
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        h_q <= h_wr;
      end
      total_q <= OW'(area);
    end
  end

  // Emit decision and neighbor validity for the current position
  always_comb begin
    col_nz   = (in_col_q != '0);
    emit_c   = ((in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && col_nz))
               && (out_count_q < total_q);
    cr       = col_nz ? (in_row_q - RW'(1)) : (in_row_q - RW'(2));
    cc       = col_nz ? (in_col_q - CW'(1)) : (w_q - CW'(1));
    top_ok   = (cr != '0);
    bot_ok   = ({1'b0, cr} + (RW+1)'(1)) < (RW+1)'(h_q);
    left_ok  = (cc != '0);
    right_ok = ({1'b0, cc} + (CW+1)'(1)) < {1'b0, w_q};
    cnt_inc  = out_count_q + OW'(1);
    last_c   = emit_c && (cnt_inc == total_q);
    col_inc  = in_col_q + CW'(1);
  end

  assign stat_o.emit     = emit_c;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  // Step position counters; restart on register write or frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_count_q <= '0;
    end else if (cfg_we_i) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_count_q <= '0;
    end else if (cmd_i.update) begin
      if (last_c) begin
        in_row_q    <= '0;
        in_col_q    <= '0;
        out_count_q <= '0;
      end else begin
        if (emit_c) begin
          out_count_q <= cnt_inc;
        end
        if (col_inc >= w_q) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= col_inc;
        end
      end
    end
  end

  // Line stores: older row in the upper half, newer row in the lower half
  assign ram_wr = {ram_rd[RGB_W-1:0], pix_q};

  bbe_ram #(
    .WIDTH(2 * RGB_W),
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .re_i   (cmd_i.accept),
    .addr_i (in_col_q[AW-1:0]),
    .wdata_i(ram_wr),
    .rdata_o(ram_rd)
  );

  // Latch request pixel; drain ticks count as black
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_data_i.cmd == CMD_DRAIN) begin
        pix_q <= '0;
      end else begin
        pix_q <= {in_data_i.pix_red, in_data_i.pix_green, in_data_i.pix_blue};
      end
    end
  end

  // Shift window left, bring in new column, capture flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      emit_q   <= 1'b0;
      last_q   <= 1'b0;
      row_ok_q <= '0;
      col_ok_q <= '0;
    end else if (cmd_i.update) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= ram_rd[2*RGB_W-1:RGB_W];
      win_q[5] <= ram_rd[RGB_W-1:0];
      win_q[8] <= pix_q;
      emit_q   <= emit_c;
      last_q   <= last_c;
      row_ok_q <= {bot_ok, 1'b1, top_ok};
      col_ok_q <= {right_ok, 1'b1, left_ok};
    end
  end

  // Add up the valid neighbors per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok_q[r] && col_ok_q[c]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(win_q[r*3+c][CH_W*ch +: CH_W]);
          end
        end
      end
    end
    rows_n  = 2'(row_ok_q[0]) + 2'(row_ok_q[1]) + 2'(row_ok_q[2]);
    cols_n  = 2'(col_ok_q[0]) + 2'(col_ok_q[1]) + 2'(col_ok_q[2]);
    count_c = CNT_W'(rows_n) * CNT_W'(cols_n);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= {sum_c[ch], 1'b0} + NUM_W'(count_c);
      end
      recip_q <= recip(count_c);
    end
  end

  // Divide by 2*count through the reciprocal
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(num_q[ch]) * PROD_W'(recip_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.scale) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      out_q.out_blue   <= prod[0][RECIP_SHIFT +: CH_W];
      out_q.out_green  <= prod[1][RECIP_SHIFT +: CH_W];
      out_q.out_red    <= prod[2][RECIP_SHIFT +: CH_W];
      out_q.frame_last <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q < w_q)
    else $error("column counter beyond frame width");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.update || out_count_q <= total_q)
    else $error("result count beyond frame size");

  a_scale_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |-> emit_q)
    else $error("result loaded for a request that emits nothing");

  a_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |-> recip_q != '0)
    else $error("empty neighborhood reached the divider");

endmodule

// File: rtl/core/box_blur_3x3_edge_average_core.sv
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    in_data_i  (cmd, pix_blue, pix_green, pix_red)
// out      out_valid_o / out_ready_i  out_data_o (out_blue, out_green, out_red, frame_last)
// cfg      cfg_we_i                   cfg_idx_i, cfg_data_i (image_width, image_height)
//
// A request that yields no result passes accept with line store read and window update;
// one that yields a result then also passes neighborhood sum and divide.
// The single-port line store and the sum/divide sequence hold each new request until the last is done.
// Reset gives a 640 x 480 frame; line store contents stay undefined until written.
// A register write restarts the frame.
// A stalled output holds the divide step; the next request is taken while a
// finished result waits in the output register.
module box_blur_3x3_edge_average_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  bbe_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [bbe_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bbe_pkg::bbe_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bbe_pkg::bbe_out_t         out_data_o
);

  import bbe_pkg::*;

  bbe_cmd_t  cmd;
  bbe_stat_t stat;

  // Sequencer
  bbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Line stores, window, averaging
  bbe_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

// File: sim/tb.sv
module tb;
  import bbe_pkg::*;

  localparam int unsigned MAX_W       = 1024;
  localparam int unsigned MAX_H       = 1024;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 800;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  cfg_idx_e         cfg_idx_i  = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  bbe_in_t          in_data_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  bbe_out_t         out_data_o;

  box_blur_3x3_edge_average_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Blur predictor state: frame size, line stores, window, stream position
  logic [CFG_W-1:0] width_reg  = 11'd640;
  logic [CFG_W-1:0] height_reg = 11'd480;
  logic [RGB_W-1:0] older_row [MAX_W];
  logic [RGB_W-1:0] newer_row [MAX_W];
  logic [RGB_W-1:0] win [9];
  int unsigned      row_pos, col_pos, frame_outs;

  bbe_in_t     pixel_q [$];
  bbe_out_t    blur_q [$];
  logic        req_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_taken = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned pushed = 0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // Advance the window by one request and queue the blurred pixel it releases
  function automatic void predict_blur(bbe_in_t req);
    int unsigned      w, h, cr, cc, cnt, sb, sg, sr, i, j;
    logic [RGB_W-1:0] pix, top, mid, v;
    bbe_out_t         res;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    pix = (req.cmd == CMD_PIXEL) ? {req.pix_red, req.pix_green, req.pix_blue} : '0;
    top = older_row[col_pos];
    mid = newer_row[col_pos];
    older_row[col_pos] = mid;
    newer_row[col_pos] = pix;
    for (i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    if ((row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) && frame_outs < w * h) begin
      if (col_pos >= 1) begin
        cr = row_pos - 1;
        cc = col_pos - 1;
      end else begin
        cr = row_pos - 2;
        cc = w - 1;
      end
      sb = 0;
      sg = 0;
      sr = 0;
      cnt = 0;
      // Sum only the neighbors that lie inside the frame
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          if (!((i == 0 && cr == 0) || (i == 2 && cr + 1 >= h) ||
                (j == 0 && cc == 0) || (j == 2 && cc + 1 >= w))) begin
            v = win[3*i+j];
            sb += v[7:0];
            sg += v[15:8];
            sr += v[23:16];
            cnt++;
          end
        end
      end
      res.out_blue  = 8'((2 * sb + cnt) / (2 * cnt));
      res.out_green = 8'((2 * sg + cnt) / (2 * cnt));
      res.out_red   = 8'((2 * sr + cnt) / (2 * cnt));
      frame_outs++;
      res.frame_last = (frame_outs == w * h);
      blur_q.push_back(res);
      if (res.frame_last) begin
        row_pos = 0;
        col_pos = 0;
        frame_outs = 0;
        return;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endfunction

  // Compare one blurred pixel with the oldest prediction
  function automatic void check_result(bbe_out_t got);
    bbe_out_t want;
    results_seen++;
    if (got.frame_last) frames_seen++;
    if (blur_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %p", got);
    end else begin
      want = blur_q.pop_front();
      if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
          got.out_red !== want.out_red || got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: expected b=%0d g=%0d r=%0d last=%0d,",
                    " got b=%0d g=%0d r=%0d last=%0d"},
                   results_seen, want.out_blue, want.out_green, want.out_red,
                   want.frame_last, got.out_blue, got.out_green, got.out_red,
                   got.frame_last);
      end
    end
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_blur(in_data_i);
      req_taken = 1'b1;
      reqs_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
  end

  // Count down a long output hold-off
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // Offer the next request, or hold the current one until taken
  always @(negedge clk_i) begin
    if (!in_valid_i || req_taken) begin
      req_taken = 1'b0;
      if (rst_ni && pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    row_pos = 0;
    col_pos = 0;
    frame_outs = 0;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(logic cmd, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    bbe_in_t req;
    req.cmd       = cmd;
    req.pix_red   = red;
    req.pix_green = green;
    req.pix_blue  = blue;
    pixel_q.push_back(req);
    pushed++;
  endtask

  // Queue one frame plus its drain tail; noisy frames mix in stray commands
  task automatic add_frame(bit noisy);
    int unsigned w, h, k;
    logic        cmd;
    w = eff_dim(width_reg, MAX_W);
    h = eff_dim(height_reg, MAX_H);
    for (k = 0; k < w * h + w + 1; k++) begin
      if (k < w * h) cmd = (noisy && $urandom_range(19) == 0) ? CMD_DRAIN : CMD_PIXEL;
      else cmd = (noisy && $urandom_range(4) == 0) ? CMD_PIXEL : CMD_DRAIN;
      push_item(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || blur_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    int unsigned phase, rand_start, wv, hv, n;
    foreach (older_row[k]) begin
      older_row[k] = '0;
      newer_row[k] = '0;
    end
    foreach (win[k]) win[k] = '0;
    row_pos = 0;
    col_pos = 0;
    frame_outs = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero width and height act as a single pixel frame
    set_idle(0, 0);
    write_reg(CFG_IMAGE_WIDTH, '0);
    write_reg(CFG_IMAGE_HEIGHT, '0);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    push_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
    wait_idle();

    // 3x3 frame: channel extremes, drain inside the frame, pixel in the tail
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(CMD_PIXEL, 8'd0, 8'd255, 8'd1);
    push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd254);
    push_item(CMD_PIXEL, 8'd128, 8'd127, 8'd3);
    push_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
    push_item(CMD_PIXEL, 8'd1, 8'd2, 8'd255);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd0);
    push_item(CMD_PIXEL, 8'd7, 8'd200, 8'd99);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Abandon a partial frame; the register write restarts it
    write_reg(CFG_IMAGE_WIDTH, 11'd2);
    write_reg(CFG_IMAGE_HEIGHT, 11'd2);
    push_item(CMD_PIXEL, 8'd9, 8'd9, 8'd9);
    push_item(CMD_PIXEL, 8'd200, 8'd100, 8'd50);
    push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 11'd2);
    push_item(CMD_PIXEL, 8'd10, 8'd20, 8'd30);
    push_item(CMD_PIXEL, 8'd255, 8'd254, 8'd253);
    push_item(CMD_PIXEL, 8'd0, 8'd1, 8'd2);
    push_item(CMD_PIXEL, 8'd77, 8'd88, 8'd99);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    push_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
    wait_idle();

    // Oversized registers clamp to the maximum frame size; run just past the
    // first row wrap so the first results of the frame come out
    set_idle(23, 23);
    write_reg(CFG_IMAGE_WIDTH, 11'd2047);
    write_reg(CFG_IMAGE_HEIGHT, 11'd2047);
    for (n = 0; n < MAX_W + 6; n++) begin
      push_item(CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
    wait_idle();

    // Random frame sizes, rotating through the idle patterns
    phase = 0;
    rand_start = pushed;
    while (pushed - rand_start < RAND_ITEMS) begin
      case (phase % 4)
        0: set_idle(0, 0);
        1: set_idle(52, 0);
        2: set_idle(0, 52);
        default: set_idle(23, 23);
      endcase
      case ($urandom_range(9))
        0: wv = 0;
        1: wv = 1;
        8: wv = $urandom_range(13, 40);
        default: wv = $urandom_range(2, 12);
      endcase
      case ($urandom_range(9))
        0: hv = 0;
        1: hv = 1;
        8: hv = $urandom_range(9, 16);
        default: hv = $urandom_range(2, 8);
      endcase
      write_reg(CFG_IMAGE_WIDTH, CFG_W'(wv));
      write_reg(CFG_IMAGE_HEIGHT, CFG_W'(hv));
      if (phase == 0) hold_start = 1'b1;
      repeat ((phase == 0) ? 3 : $urandom_range(1, 3)) add_frame(1'b1);
      wait_idle();
      phase++;
    end

    wait_idle();
    $display("Checked %0d blurred pixels (%0d frames) from %0d requests", results_seen,
             frames_seen, reqs_taken);
    $display("over %0d register writes and %0d random phases; %0d mismatches", cfg_writes,
             phase, mismatches);
    if (mismatches == 0) begin
      $display("[box_blur_3x3_edge_average_core] OK");
    end else begin
      $display("[box_blur_3x3_edge_average_core] ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #16000000;
    $display("[box_blur_3x3_edge_average_core] ERROR");
    $finish;
  end

endmodule
